// ----- design/i2cbc_pkg.sv -----
package i2cbc_pkg;

    // width of the bus delay counter
    localparam int DELAY_WIDTH = 24;

    // command codes carried in op
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_WRITE   = 3'd3,
        OP_READ    = 3'd4,
        OP_RECOVER = 3'd5
    } op_code_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_STEP_TICKS    = 2'd0,
        REG_ACK_LIMIT     = 2'd1,
        REG_RECOVER_TICKS = 2'd2,
        REG_RECOVER_PULSE = 2'd3
    } cfg_index_t;

    localparam logic [15:0] STEP_TICKS_RST     = 16'd100;
    localparam logic [7:0]  ACK_LIMIT_RST      = 8'd200;
    localparam logic [23:0] RECOVER_TICKS_RST  = 24'd100000;
    localparam logic [3:0]  RECOVER_PULSES_RST = 4'd9;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_level;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_fail;
        logic       bus_was_stuck;
    } out_item_t;

endpackage

// ----- design/i2c_byte_command_master.sv -----
// i2c byte command master
//
// s_ channel: one item per bus timer tick. op carries a command (start, stop,
// write byte, read byte, bus recovery) that is taken only while the block is
// idle; otherwise op is ignored and the tick just advances the sequencer.
// sda_level is the sampled SDA line for that tick.
// m_ channel: exactly one result item per input item, giving the open-drain
// line levels, busy and done flags, last read byte and the fail/stuck flags.
// cfg_ channel: register writes (step ticks, ack poll limit, recovery half
// period, recovery pulse count), always ready, one per cycle.
//
// the result is registered: it is available in the cycle after its item is accepted.
// throughput: one item per cycle; the whole tick update is one pass of
// combinational logic between the state registers and the result register.
// a stalled m_ side holds the result; s_ready drops only while that result
// waits and is not being taken in the same cycle.
// reset (aresetn low, synchronous): sequencer idle, both lines released,
// flags and read byte cleared, registers back to their defaults.
module i2c_byte_command_master (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  i2cbc_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2cbc_pkg::out_item_t  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data
);
    import i2cbc_pkg::*;

    localparam logic [31:0] DELAY_MAX = 32'((64'd1 << DELAY_WIDTH) - 64'd1);

    // sequencer phases, one-hot
    typedef enum logic [24:0] {
        PH_IDLE = 25'd1,
        PH_ST1  = 25'd1 << 1,
        PH_ST2  = 25'd1 << 2,
        PH_ST3  = 25'd1 << 3,
        PH_SP1  = 25'd1 << 4,
        PH_SP2  = 25'd1 << 5,
        PH_SP3  = 25'd1 << 6,
        PH_WR0  = 25'd1 << 7,
        PH_WRD  = 25'd1 << 8,
        PH_WRH  = 25'd1 << 9,
        PH_WRN  = 25'd1 << 10,
        PH_AKR  = 25'd1 << 11,
        PH_AKP  = 25'd1 << 12,
        PH_RD0  = 25'd1 << 13,
        PH_RDH  = 25'd1 << 14,
        PH_RDS  = 25'd1 << 15,
        PH_RDL  = 25'd1 << 16,
        PH_RAS  = 25'd1 << 17,
        PH_RAH  = 25'd1 << 18,
        PH_RAL  = 25'd1 << 19,
        PH_RC0  = 25'd1 << 20,
        PH_RCC  = 25'd1 << 21,
        PH_RCL  = 25'd1 << 22,
        PH_RCH  = 25'd1 << 23,
        PH_FIN  = 25'd1 << 24
    } phase_t;

    // configuration registers
    logic [15:0] step_ticks_reg;
    logic [7:0]  ack_limit_reg;
    logic [23:0] recover_ticks_reg;
    logic [3:0]  recover_pulses_reg;

    // sequencer state
    phase_t                 phase_reg, phase_next, cur_phase;
    logic [2:0]             cmd_reg, cmd_next;
    logic [DELAY_WIDTH-1:0] delay_reg, delay_next;
    logic [3:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic [7:0]             poll_reg, poll_next;
    logic [3:0]             pulse_reg, pulse_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic                   ack_reg, ack_next;
    logic                   fail_reg, fail_next;
    logic                   stuck_reg, stuck_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   done_now;
    logic                   do_act;

    // result register
    out_item_t m_data_reg;
    logic      m_valid_reg;

    logic        s_accept;
    logic [15:0] half_ticks;
    logic [15:0] rest_ticks;
    logic [23:0] step_ticks24;

    // wait length: ticks - 1, saturated to the counter width
    function automatic logic [DELAY_WIDTH-1:0] delay_of(input logic [23:0] ticks);
        logic [23:0] tm1;
        logic [31:0] wide;
        tm1 = (ticks == 24'd0) ? 24'd0 : ticks - 24'd1;
        wide = 32'(tm1);
        if (wide > DELAY_MAX) begin
            wide = DELAY_MAX;
        end
        return DELAY_WIDTH'(wide);
    endfunction

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    assign half_ticks   = step_ticks_reg >> 1;
    assign rest_ticks   = step_ticks_reg - half_ticks;
    assign step_ticks24 = 24'(step_ticks_reg);

    // one tick of the sequencer
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        delay_next = delay_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        pulse_next = pulse_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        fail_next  = fail_reg;
        stuck_next = stuck_reg;
        rx_next    = rx_reg;
        done_now   = 1'b0;
        do_act     = 1'b0;
        cur_phase  = phase_reg;

        if (phase_reg == PH_IDLE) begin
            do_act = 1'b1;
            cmd_next = s_data.op;
            case (s_data.op)
                OP_START:   cur_phase = PH_ST1;
                OP_STOP:    cur_phase = PH_SP1;
                OP_WRITE: begin
                    cur_phase  = PH_WR0;
                    shift_next = s_data.tx_byte;
                    fail_next  = 1'b0;
                end
                OP_READ: begin
                    cur_phase = PH_RD0;
                    ack_next  = s_data.send_ack;
                end
                OP_RECOVER: cur_phase = PH_RC0;
                default: begin
                    // no command, or an unused code
                    do_act   = 1'b0;
                    cmd_next = cmd_reg;
                end
            endcase
        end else if (delay_reg != '0) begin
            delay_next = delay_reg - 1'b1;
        end else begin
            do_act = 1'b1;
        end

        if (do_act) begin
            unique case (cur_phase)
                PH_ST1: begin
                    sda_next = 1'b1; scl_next = 1'b1;
                    delay_next = delay_of(step_ticks24); phase_next = PH_ST2;
                end
                PH_ST2: begin
                    sda_next = 1'b0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_ST3;
                end
                PH_ST3: begin
                    scl_next = 1'b0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_FIN;
                end
                PH_SP1: begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_SP2;
                end
                PH_SP2: begin
                    scl_next = 1'b1;
                    delay_next = delay_of(step_ticks24); phase_next = PH_SP3;
                end
                PH_SP3: begin
                    sda_next = 1'b1;
                    delay_next = delay_of(step_ticks24); phase_next = PH_FIN;
                end
                PH_WR0: begin
                    scl_next = 1'b0; bit_next = 4'd0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_WRD;
                end
                PH_WRD: begin
                    sda_next = shift_next[7];
                    delay_next = delay_of(step_ticks24); phase_next = PH_WRH;
                end
                PH_WRH: begin
                    scl_next = 1'b1;
                    delay_next = delay_of(step_ticks24); phase_next = PH_WRN;
                end
                PH_WRN: begin
                    scl_next   = 1'b0;
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_reg + 4'd1;
                    delay_next = delay_of(step_ticks24);
                    phase_next = (bit_next >= 4'd8) ? PH_AKR : PH_WRD;
                end
                PH_AKR: begin
                    sda_next = 1'b1; scl_next = 1'b1; poll_next = 8'd0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_AKP;
                end
                PH_AKP: begin
                    if (!s_data.sda_level) begin
                        scl_next = 1'b0;
                        delay_next = delay_of(step_ticks24); phase_next = PH_FIN;
                    end else if (poll_reg >= ack_limit_reg) begin
                        // timeout: flag it and go straight into the stop sequence
                        fail_next = 1'b1;
                        scl_next = 1'b0; sda_next = 1'b0;
                        delay_next = delay_of(step_ticks24); phase_next = PH_SP2;
                    end else begin
                        poll_next  = poll_reg + 8'd1;
                        delay_next = '0;
                        phase_next = PH_AKP;
                    end
                end
                PH_RD0: begin
                    sda_next = 1'b1; scl_next = 1'b0;
                    bit_next = 4'd0; shift_next = 8'd0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_RDH;
                end
                PH_RDH: begin
                    scl_next = 1'b1;
                    delay_next = delay_of(24'(half_ticks)); phase_next = PH_RDS;
                end
                PH_RDS: begin
                    // sample at mid-high of scl
                    shift_next = {shift_reg[6:0], s_data.sda_level};
                    bit_next   = bit_reg + 4'd1;
                    delay_next = delay_of(24'(rest_ticks));
                    if (bit_next >= 4'd8) begin
                        rx_next    = shift_next;
                        phase_next = PH_RAS;
                    end else begin
                        phase_next = PH_RDL;
                    end
                end
                PH_RDL: begin
                    scl_next = 1'b0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_RDH;
                end
                PH_RAS: begin
                    scl_next = 1'b0; sda_next = !ack_reg;
                    delay_next = delay_of(step_ticks24); phase_next = PH_RAH;
                end
                PH_RAH: begin
                    scl_next = 1'b1;
                    delay_next = delay_of(step_ticks24); phase_next = PH_RAL;
                end
                PH_RAL: begin
                    scl_next = 1'b0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_FIN;
                end
                PH_RC0: begin
                    sda_next = 1'b1; stuck_next = 1'b0;
                    delay_next = delay_of(step_ticks24); phase_next = PH_RCC;
                end
                PH_RCC: begin
                    if (s_data.sda_level) begin
                        done_now = 1'b1; phase_next = PH_IDLE; delay_next = '0;
                        scl_next = 1'b1;
                    end else begin
                        stuck_next = 1'b1; pulse_next = 4'd0;
                        if (recover_pulses_reg == 4'd0) begin
                            done_now = 1'b1; phase_next = PH_IDLE; delay_next = '0;
                            scl_next = 1'b1;
                        end else begin
                            scl_next = 1'b1;
                            delay_next = delay_of(recover_ticks_reg);
                            phase_next = PH_RCL;
                        end
                    end
                end
                PH_RCL: begin
                    scl_next   = 1'b0;
                    pulse_next = pulse_reg + 4'd1;
                    delay_next = delay_of(recover_ticks_reg);
                    phase_next = (pulse_next >= recover_pulses_reg) ? PH_FIN : PH_RCH;
                end
                PH_RCH: begin
                    scl_next = 1'b1;
                    delay_next = delay_of(recover_ticks_reg); phase_next = PH_RCL;
                end
                default: begin
                    // finishing tick; recovery ends with scl released
                    if (cmd_next == OP_RECOVER) begin
                        scl_next = 1'b1;
                    end
                    done_now = 1'b1; phase_next = PH_IDLE; delay_next = '0;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ticks_reg     <= STEP_TICKS_RST;
            ack_limit_reg      <= ACK_LIMIT_RST;
            recover_ticks_reg  <= RECOVER_TICKS_RST;
            recover_pulses_reg <= RECOVER_PULSES_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STEP_TICKS:    step_ticks_reg     <= cfg_data[15:0];
                REG_ACK_LIMIT:     ack_limit_reg      <= cfg_data[7:0];
                REG_RECOVER_TICKS: recover_ticks_reg  <= cfg_data;
                REG_RECOVER_PULSE: recover_pulses_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer state advances once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= 3'd0;
            delay_reg <= '0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            pulse_reg <= 4'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            fail_reg  <= 1'b0;
            stuck_reg <= 1'b0;
            rx_reg    <= 8'd0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            delay_reg <= delay_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            pulse_reg <= pulse_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            fail_reg  <= fail_next;
            stuck_reg <= stuck_next;
            rx_reg    <= rx_next;
        end
    end

    // result register: holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg.scl_out       <= scl_next;
            m_data_reg.sda_out       <= sda_next;
            m_data_reg.busy_res      <= (phase_next != PH_IDLE);
            m_data_reg.done_res      <= done_now;
            m_data_reg.rx_byte       <= rx_next;
            m_data_reg.ack_fail      <= fail_next;
            m_data_reg.bus_was_stuck <= stuck_next;
        end
    end

`ifndef SYNTHESIS
    // a finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> !m_data.busy_res)
        else $error("done result reported busy");

    // idle sequencer carries no pending wait
    a_idle_no_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (delay_reg == '0))
        else $error("idle with delay pending");

    // ack polling only after all eight bits went out
    a_ack_after_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_AKP) |-> (bit_reg == 4'd8))
        else $error("ack poll before byte complete");

    // every accepted item yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted item produced no result");
`endif

endmodule

// ----- tb/i2cbc_bus_checker.sv -----
module i2cbc_bus_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  i2cbc_pkg::in_item_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  i2cbc_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    output int                   mismatch_count,
    output int                   results_owed,
    output logic                 seq_idle
);
    import i2cbc_pkg::*;

    typedef enum logic [4:0] {
        IDLE, START_HI, START_SDA, START_SCL, STOP_LOW, STOP_SCL, STOP_SDA,
        WR_SCL_LOW, WR_BIT, WR_SCL_HI, WR_SCL_LO, ACK_RELEASE, ACK_POLL,
        RD_SETUP, RD_SCL_HI, RD_SAMPLE, RD_SCL_LO, RACK_DRIVE, RACK_HI, RACK_LO,
        RC_RELEASE, RC_CHECK, RC_SCL_LO, RC_SCL_HI, WRAP_UP
    } seq_phase_t;

    // register copies
    logic [15:0] step_cfg;
    logic [7:0]  ack_limit_cfg;
    logic [23:0] rec_ticks_cfg;
    logic [3:0]  rec_pulses_cfg;

    // sequencer copy
    seq_phase_t             phase;
    op_code_t               cmd;
    logic [DELAY_WIDTH-1:0] wait_left;
    logic [3:0]             bit_cnt;
    logic [7:0]             shreg;
    logic [7:0]             poll_cnt;
    logic [3:0]             pulse_cnt;
    logic                   scl_q, sda_q, ack_q, fail_q, stuck_q, done_q;
    logic [7:0]             rx_q;

    out_item_t tick_results_due[$];

    assign seq_idle = (phase == IDLE);

    function automatic void model_reset();
        step_cfg       = STEP_TICKS_RST;
        ack_limit_cfg  = ACK_LIMIT_RST;
        rec_ticks_cfg  = RECOVER_TICKS_RST;
        rec_pulses_cfg = RECOVER_PULSES_RST;
        phase     = IDLE;
        cmd       = OP_NONE;
        wait_left = '0;
        bit_cnt   = '0;
        shreg     = '0;
        poll_cnt  = '0;
        pulse_cnt = '0;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        ack_q     = 1'b0;
        fail_q    = 1'b0;
        stuck_q   = 1'b0;
        done_q    = 1'b0;
        rx_q      = '0;
    endfunction

    // a step acts for one tick, then idles ticks-1 more (saturating)
    function automatic void hold_for(seq_phase_t next, logic [31:0] ticks);
        logic [63:0] span;
        span = (ticks != 0) ? 64'(ticks) - 64'd1 : 64'd0;
        if (span > ((64'd1 << DELAY_WIDTH) - 64'd1)) wait_left = '1;
        else wait_left = span[DELAY_WIDTH-1:0];
        phase = next;
    endfunction

    function automatic void end_cmd();
        if (cmd == OP_RECOVER) scl_q = 1'b1;
        done_q    = 1'b1;
        phase     = IDLE;
        wait_left = '0;
    endfunction

    function automatic void seq_step(logic sda);
        logic [31:0] full, half;
        full = 32'(step_cfg);
        half = full >> 1;
        case (phase)
            START_HI: begin
                sda_q = 1'b1; scl_q = 1'b1; hold_for(START_SDA, full);
            end
            START_SDA: begin
                sda_q = 1'b0; hold_for(START_SCL, full);
            end
            START_SCL: begin
                scl_q = 1'b0; hold_for(WRAP_UP, full);
            end
            STOP_LOW: begin
                scl_q = 1'b0; sda_q = 1'b0; hold_for(STOP_SCL, full);
            end
            STOP_SCL: begin
                scl_q = 1'b1; hold_for(STOP_SDA, full);
            end
            STOP_SDA: begin
                sda_q = 1'b1; hold_for(WRAP_UP, full);
            end
            WR_SCL_LOW: begin
                scl_q = 1'b0; bit_cnt = '0; hold_for(WR_BIT, full);
            end
            WR_BIT: begin
                sda_q = shreg[7]; hold_for(WR_SCL_HI, full);
            end
            WR_SCL_HI: begin
                scl_q = 1'b1; hold_for(WR_SCL_LO, full);
            end
            WR_SCL_LO: begin
                scl_q   = 1'b0;
                shreg   = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) hold_for(ACK_RELEASE, full);
                else hold_for(WR_BIT, full);
            end
            ACK_RELEASE: begin
                sda_q = 1'b1; scl_q = 1'b1; poll_cnt = '0; hold_for(ACK_POLL, full);
            end
            ACK_POLL: begin
                if (!sda) begin
                    scl_q = 1'b0; hold_for(WRAP_UP, full);
                end else if (poll_cnt >= ack_limit_cfg) begin
                    // timeout goes straight into the stop sequence
                    fail_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0; hold_for(STOP_SCL, full);
                end else begin
                    poll_cnt = poll_cnt + 8'd1; hold_for(ACK_POLL, 32'd0);
                end
            end
            RD_SETUP: begin
                sda_q = 1'b1; scl_q = 1'b0; bit_cnt = '0; shreg = '0;
                hold_for(RD_SCL_HI, full);
            end
            RD_SCL_HI: begin
                scl_q = 1'b1; hold_for(RD_SAMPLE, half);
            end
            RD_SAMPLE: begin
                shreg   = {shreg[6:0], sda};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                    rx_q = shreg; hold_for(RACK_DRIVE, full - half);
                end else begin
                    hold_for(RD_SCL_LO, full - half);
                end
            end
            RD_SCL_LO: begin
                scl_q = 1'b0; hold_for(RD_SCL_HI, full);
            end
            RACK_DRIVE: begin
                scl_q = 1'b0; sda_q = !ack_q; hold_for(RACK_HI, full);
            end
            RACK_HI: begin
                scl_q = 1'b1; hold_for(RACK_LO, full);
            end
            RACK_LO: begin
                scl_q = 1'b0; hold_for(WRAP_UP, full);
            end
            RC_RELEASE: begin
                sda_q = 1'b1; stuck_q = 1'b0; hold_for(RC_CHECK, full);
            end
            RC_CHECK: begin
                if (sda) begin
                    end_cmd();
                end else begin
                    stuck_q = 1'b1; pulse_cnt = '0;
                    if (rec_pulses_cfg == 4'd0) end_cmd();
                    else begin
                        scl_q = 1'b1; hold_for(RC_SCL_LO, 32'(rec_ticks_cfg));
                    end
                end
            end
            RC_SCL_LO: begin
                scl_q     = 1'b0;
                pulse_cnt = pulse_cnt + 4'd1;
                if (pulse_cnt >= rec_pulses_cfg) hold_for(WRAP_UP, 32'(rec_ticks_cfg));
                else hold_for(RC_SCL_HI, 32'(rec_ticks_cfg));
            end
            RC_SCL_HI: begin
                scl_q = 1'b1; hold_for(RC_SCL_LO, 32'(rec_ticks_cfg));
            end
            default: end_cmd();
        endcase
    endfunction

    function automatic out_item_t bus_tick(in_item_t it);
        out_item_t res;
        done_q = 1'b0;
        if (phase == IDLE) begin
            if (it.op >= OP_START && it.op <= OP_RECOVER) begin
                cmd = op_code_t'(it.op);
                case (cmd)
                    OP_START: phase = START_HI;
                    OP_STOP:  phase = STOP_LOW;
                    OP_WRITE: begin
                        shreg = it.tx_byte; fail_q = 1'b0; phase = WR_SCL_LOW;
                    end
                    OP_READ: begin
                        ack_q = it.send_ack; phase = RD_SETUP;
                    end
                    default: phase = RC_RELEASE;
                endcase
                seq_step(it.sda_level);
            end
        end else if (wait_left != 0) begin
            wait_left = wait_left - 1'b1;
        end else begin
            seq_step(it.sda_level);
        end
        res.scl_out       = scl_q;
        res.sda_out       = sda_q;
        res.busy_res      = (phase != IDLE);
        res.done_res      = done_q;
        res.rx_byte       = rx_q;
        res.ack_fail      = fail_q;
        res.bus_was_stuck = stuck_q;
        return res;
    endfunction

    always @(posedge aclk) begin : check_edge
        out_item_t want;
        if (!aresetn) begin
            model_reset();
            tick_results_due.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (tick_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result item with nothing outstanding", $time);
                end else begin
                    want = tick_results_due.pop_front();
                    if (m_data !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: exp/got scl %b/%b sda %b/%b busy %b/%b done %b/%b",
                                      " rx %h/%h fail %b/%b stuck %b/%b"}, $time,
                                     want.scl_out, m_data.scl_out, want.sda_out, m_data.sda_out,
                                     want.busy_res, m_data.busy_res,
                                     want.done_res, m_data.done_res,
                                     want.rx_byte, m_data.rx_byte,
                                     want.ack_fail, m_data.ack_fail,
                                     want.bus_was_stuck, m_data.bus_was_stuck);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    REG_STEP_TICKS:    step_cfg       = cfg_data[15:0];
                    REG_ACK_LIMIT:     ack_limit_cfg  = cfg_data[7:0];
                    REG_RECOVER_TICKS: rec_ticks_cfg  = cfg_data;
                    default:           rec_pulses_cfg = cfg_data[3:0];
                endcase
            end
            if (s_valid && s_ready)
                tick_results_due.push_back(bus_tick(s_data));
        end
        results_owed = tick_results_due.size();
    end

endmodule

// ----- tb/tb_i2c_byte_command_master.sv -----
module tb_i2c_byte_command_master;
    import i2cbc_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    int   mismatch_count;
    int   results_owed;
    logic seq_idle;

    // sender burst bookkeeping
    int burst_left = 0;
    // asks the result sink for one long hold-off
    bit hold_now = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    i2c_byte_command_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts every result item and compares
    i2cbc_bus_checker line_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .seq_idle       (seq_idle)
    );

    // sda level drawn high with the given percentage
    function automatic logic sda_draw(int pct);
        return ($urandom_range(99) < pct);
    endfunction

    // offer one item; called and returning at a falling edge, valid left high
    task automatic send_item(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            // a quarter of the bursts follow straight on
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        @(negedge aclk);
    endtask

    // keep ticking until the running command is over
    task automatic settle(int pct, bit noisy);
        in_item_t it;
        while (!seq_idle) begin
            it           = '0;
            it.tx_byte   = 8'($urandom);
            it.send_ack  = 1'($urandom);
            it.sda_level = sda_draw(pct);
            // noisy ticks carry ops that a busy block must ignore
            if (noisy) it.op = 3'($urandom_range(7));
            send_item(it);
        end
    endtask

    task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack, int pct, bit noisy);
        in_item_t it;
        it.op        = op;
        it.tx_byte   = tx;
        it.send_ack  = ack;
        it.sda_level = sda_draw(pct);
        send_item(it);
        settle(pct, noisy);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // new bus timing, only once the block is idle and every result is in
    task automatic load_timing(logic [15:0] step, logic [7:0] ack_lim,
                               logic [23:0] rc_ticks, logic [3:0] rc_pulses);
        s_valid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        // junk above the width of the step, ack limit and pulse count registers must be dropped
        write_reg(REG_STEP_TICKS,    {8'($urandom), step});
        write_reg(REG_ACK_LIMIT,     {16'($urandom), ack_lim});
        write_reg(REG_RECOVER_TICKS, rc_ticks);
        write_reg(REG_RECOVER_PULSE, {20'($urandom), rc_pulses});
    endtask

    // random ticks: commands mostly when idle, stray ops while busy
    task automatic random_phase(int count);
        in_item_t it;
        int n, pct, pick;
        pct = 50;
        for (n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(5))
                    0:       pct = 0;
                    1:       pct = 30;
                    2:       pct = 50;
                    3:       pct = 80;
                    4:       pct = 95;
                    default: pct = 100;
                endcase
            end
            it.tx_byte   = 8'($urandom);
            it.send_ack  = 1'($urandom);
            it.sda_level = sda_draw(pct);
            pick         = $urandom_range(15);
            if (seq_idle) begin
                if (pick < 8) it.op = OP_NONE;
                else if (pick < 14) it.op = 3'($urandom_range(OP_START, OP_RECOVER));
                else it.op = 3'($urandom_range(6, 7));
            end else begin
                if (pick == 0) it.op = 3'($urandom_range(7));
                else it.op = OP_NONE;
            end
            send_item(it);
        end
        settle(pct, 1'b0);
    endtask

    // result side: stall patterns of its own, plus one long hold-off
    initial begin : result_sink
        int span, style, k;
        forever begin
            if (hold_now) begin
                hold_now = 1'b0;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            span  = $urandom_range(8, 120);
            style = $urandom_range(3);
            for (k = 0; k < span; k++) begin
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(1));
                    2:       m_ready <= ((k % 5) != 4);
                    default: m_ready <= ((k % 7) < 2);
                endcase
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int p;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing: step 100, bus free so no pulses
        run_cmd(OP_RECOVER, 8'h00, 1'b0, 100, 1'b0);

        // zero step registers, ack limit zero, zero recover pulses
        load_timing(16'd0, 8'd0, 24'd0, 4'd0);
        run_cmd(OP_WRITE,   8'h00, 1'b1, 100, 1'b0);  // first high sample times out
        run_cmd(OP_RECOVER, 8'hFF, 1'b1, 0,   1'b0);  // stuck but nothing to send
        run_cmd(OP_READ,    8'h00, 1'b1, 100, 1'b0);  // all ones, ack
        run_cmd(OP_READ,    8'hFF, 1'b0, 0,   1'b0);  // all zeros, nack
        run_cmd(3'd6,       8'hFF, 1'b1, 50,  1'b0);  // unused codes do nothing
        run_cmd(3'd7,       8'h00, 1'b0, 50,  1'b0);
        run_cmd(OP_STOP,    8'h3C, 1'b0, 50,  1'b0);
        run_cmd(OP_WRITE,   8'hFF, 1'b0, 0,   1'b0);  // acked at once

        // shortest odd step, most recover pulses
        load_timing(16'd1, 8'd3, 24'd1, 4'd15);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, 0,   1'b0);
        run_cmd(OP_WRITE,   8'h5A, 1'b1, 100, 1'b0);
        run_cmd(OP_START,   8'h00, 1'b0, 50,  1'b1);  // ops thrown at a busy block
        run_cmd(OP_READ,    8'h00, 1'b1, 50,  1'b1);
        run_cmd(OP_WRITE,   8'h81, 1'b0, 50,  1'b1);

        // even step so the sample splits the high phase
        load_timing(16'd2, 8'd1, 24'd3, 4'd1);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, 0,  1'b0);
        run_cmd(OP_READ,    8'h00, 1'b0, 50, 1'b0);
        run_cmd(OP_WRITE,   8'h7E, 1'b1, 80, 1'b0);
        run_cmd(OP_STOP,    8'h00, 1'b0, 50, 1'b0);

        // random part; the sink holds off once early on
        hold_now = 1'b1;
        for (p = 0; p < 6; p++) begin
            if (p == 2) load_timing(16'd1, 8'd255, 24'd2, 4'd15);
            else load_timing(16'($urandom_range(0, 6)), 8'($urandom_range(0, 12)),
                             24'($urandom_range(0, 5)), 4'($urandom_range(15)));
            random_phase(200);
        end

        // largest limits with a short step; a free bus recovery and an acked
        // write never wait on them
        load_timing(16'd3, 8'hFF, 24'hFFFFFF, 4'hF);
        run_cmd(OP_RECOVER, 8'h00, 1'b0, 100, 1'b0);
        run_cmd(OP_WRITE,   8'h96, 1'b1, 0,   1'b0);

        s_valid <= 1'b0;
        while (results_owed != 0) @(negedge aclk);
        // one registered result per item, so a short tail is plenty
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ends the run with FAIL should the stimulus hang
    initial begin : watchdog
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
